// File: design/mpct_pkg.sv
// Shared types and constants for the mouse packet cursor tracker.
package mpct_pkg;

  localparam int COORD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int SIZE_BITS = 13;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET = 13'd1024;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 13'd768;

  // Register byte addresses
  localparam logic [2:0] ADDR_SCREEN_WIDTH = 3'd0;
  localparam logic [2:0] ADDR_SCREEN_HEIGHT = 3'd4;

  // Bit of the header byte that marks a valid packet start
  localparam int HDR_SYNC_BIT = 3;

  typedef enum logic [2:0] {
    PH_HEAD = 3'b001,
    PH_XDAT = 3'b010,
    PH_YDAT = 3'b100
  } phase_t;

  // One assembled packet, as handed from front to back
  typedef struct packed {
    logic       btn_middle;
    logic       btn_right;
    logic       btn_left;
    logic [7:0] x_byte;
    logic [7:0] y_byte;
  } pkt_t;

  // Queue write control from the front: push request and the full flag it sees
  typedef struct packed {
    logic full;
    logic push;
  } q_ctl_t;

endpackage

// File: design/mpct_front.sv
// Front end: byte phase tracking and packet assembly.
module mpct_front
  import mpct_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       q_full,
  output q_ctl_t     q_ctl,
  output pkt_t       q_pkt
);

  phase_t     phase_r, phase_nxt;
  logic [2:0] btn_r;
  logic [7:0] xb_r;
  logic       accept;

  // Only the closing byte needs room in the queue
  assign in_tready = (phase_r != PH_YDAT) || !q_full;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    phase_nxt = phase_r;
    if (accept) begin
      case (phase_r)
        PH_HEAD: begin
          phase_nxt = in_tdata[HDR_SYNC_BIT] ? PH_XDAT : PH_HEAD;
        end
        PH_XDAT: begin
          phase_nxt = PH_YDAT;
        end
        PH_YDAT: begin
          phase_nxt = PH_HEAD;
        end
        default: begin
          phase_nxt = PH_HEAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEAD;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && phase_r == PH_HEAD) begin
      btn_r <= in_tdata[2:0];
    end
    if (accept && phase_r == PH_XDAT) begin
      xb_r <= in_tdata;
    end
  end

  assign q_ctl.full = q_full;
  assign q_ctl.push = accept && (phase_r == PH_YDAT);

  assign q_pkt.btn_middle = btn_r[2];
  assign q_pkt.btn_right  = btn_r[1];
  assign q_pkt.btn_left   = btn_r[0];
  assign q_pkt.x_byte     = xb_r;
  assign q_pkt.y_byte     = in_tdata;

endmodule

// File: design/mpct_queue.sv
// Short packet queue between front and back.
module mpct_queue
  import mpct_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  input  q_ctl_t wr_ctl,
  input  pkt_t   wr_pkt,
  output logic   full,
  output logic   rd_valid,
  input  logic   rd_pop,
  output pkt_t   rd_pkt
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  pkt_t          mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr, do_rd;

  assign full     = (cnt_r == CW'(DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign do_wr    = wr_ctl.push && !wr_ctl.full;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_pkt   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wp_r] <= wr_pkt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) begin
        wp_r <= (wp_r == LAST) ? '0 : wp_r + 1'b1;
      end
      if (do_rd) begin
        rp_r <= (rp_r == LAST) ? '0 : rp_r + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// File: design/mpct_back.sv
// Back end: cursor update, clamping and result register.
module mpct_back
  import mpct_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [SIZE_BITS-1:0]  screen_width,
  input  logic [SIZE_BITS-1:0]  screen_height,
  input  logic                  q_valid,
  input  pkt_t                  q_pkt,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] pos_x,
  output logic [COORD_BITS-1:0] pos_y,
  output logic [2:0]            buttons
);

  localparam int LW = (COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS;
  localparam int SW = LW + 2;
  localparam logic [LW-1:0] CMAX = LW'((1 << COORD_BITS) - 1);

  logic                  valid_r;
  logic [COORD_BITS-1:0] x_r, y_r;
  logic [2:0]            btn_r;
  logic [LW-1:0]         lim_x, lim_y;
  logic signed [SW-1:0]  sum_x, sum_y;
  logic [COORD_BITS-1:0] x_nxt, y_nxt;

  function automatic logic [LW-1:0] limit_of(input logic [SIZE_BITS-1:0] size);
    logic [LW-1:0] lim;
    lim = (size == '0) ? '0 : LW'(size - 1'b1);
    return (lim > CMAX) ? CMAX : lim;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp(input logic signed [SW-1:0] v,
                                                  input logic [LW-1:0] lim);
    logic [COORD_BITS-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed({2'b00, lim})) begin
      res = COORD_BITS'(lim);
    end else begin
      res = COORD_BITS'(v);
    end
    return res;
  endfunction

  assign lim_x = limit_of(screen_width);
  assign lim_y = limit_of(screen_height);

  // Y grows downward, so the mouse delta is subtracted
  assign sum_x = $signed(SW'(x_r)) + SW'($signed(q_pkt.x_byte));
  assign sum_y = $signed(SW'(y_r)) - SW'($signed(q_pkt.y_byte));
  assign x_nxt = clamp(sum_x, lim_x);
  assign y_nxt = clamp(sum_y, lim_y);

  assign q_pop = q_valid && (!valid_r || out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      x_r     <= '0;
      y_r     <= '0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
      x_r     <= x_nxt;
      y_r     <= y_nxt;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      btn_r <= {q_pkt.btn_middle, q_pkt.btn_right, q_pkt.btn_left};
    end
  end

  assign out_valid = valid_r;
  assign pos_x     = x_r;
  assign pos_y     = y_r;
  assign buttons   = btn_r;

endmodule

// File: design/mouse_packet_cursor_tracker_core.sv
// Top level of the mouse packet cursor tracker.
// Takes one received mouse byte per cycle on the in_ stream, unless a full
// queue holds back a packet's closing byte, and assembles 3-byte packets; a
// header byte without bit 3 set is dropped to regain sync. Each completed
// packet moves the cursor by the signed X delta and minus the signed Y delta,
// clamped to the screen limits held in the configuration registers, and
// yields one item on the out_ stream carrying the position and the three
// buttons. The front end tracks the byte phase in a register; the back end
// adds and clamps combinationally ahead of its result register. A completed
// packet passes through the packet queue between the two halves, which lets
// input keep flowing while the output is stalled, until the queue fills.
module mouse_packet_cursor_tracker_core
  import mpct_pkg::*;
#(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // out_tdata from bit 0: cursor_x, cursor_y, button_left, button_right,
  // button_middle, zero fill
  output logic [((2*COORD_BITS+3+7)/8)*8-1:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int OW = ((2*COORD_BITS+3+7)/8)*8;
  localparam int PADW = OW - (2*COORD_BITS+3);

  logic [SIZE_BITS-1:0]  width_r, height_r;
  logic                  cfg_wr;
  logic                  q_full, q_valid, q_pop;
  q_ctl_t                q_ctl;
  pkt_t                  wr_pkt, rd_pkt;
  logic [COORD_BITS-1:0] pos_x, pos_y;
  logic [2:0]            buttons;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      if (cfg_paddr == ADDR_SCREEN_WIDTH) begin
        width_r <= cfg_pwdata[SIZE_BITS-1:0];
      end
      if (cfg_paddr == ADDR_SCREEN_HEIGHT) begin
        height_r <= cfg_pwdata[SIZE_BITS-1:0];
      end
    end
  end

  always_comb begin
    case (cfg_paddr)
      ADDR_SCREEN_WIDTH:  cfg_prdata = 32'(width_r);
      ADDR_SCREEN_HEIGHT: cfg_prdata = 32'(height_r);
      default:            cfg_prdata = '0;
    endcase
  end

  mpct_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .q_ctl     (q_ctl),
    .q_pkt     (wr_pkt)
  );

  mpct_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_ctl   (q_ctl),
    .wr_pkt   (wr_pkt),
    .full     (q_full),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_pkt   (rd_pkt)
  );

  mpct_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .screen_width  (width_r),
    .screen_height (height_r),
    .q_valid       (q_valid),
    .q_pkt         (rd_pkt),
    .q_pop         (q_pop),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .pos_x         (pos_x),
    .pos_y         (pos_y),
    .buttons       (buttons)
  );

  assign out_tdata = {{PADW{1'b0}}, buttons[2], buttons[1], buttons[0], pos_y, pos_x};

endmodule
